// ===== sv/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes, reset values and the multiplier command
// type used by the serial arithmetic units of the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_FRAC_BITS  = 16;

	localparam int GAIN_W    = 32;
	localparam int DRV_W     = 32;
	localparam int LIM_W     = 47;
	localparam int MS_W      = 16;
	localparam int CFG_W     = 47;
	localparam int CFG_IDX_W = 3;

	localparam int SCALE   = 1000;
	localparam int SCALE_W = 10;

	localparam int DIGIT_W   = 4;
	localparam int DIV_STEPS = 2;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_P_RST    = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] GAIN_I_RST    = '0;
	localparam logic [GAIN_W-1:0] GAIN_D_RST    = '0;
	localparam logic [DRV_W-1:0]  DRIVE_MIN_RST = {1'b1, {(DRV_W-1){1'b0}}};
	localparam logic [DRV_W-1:0]  DRIVE_MAX_RST = {1'b0, {(DRV_W-1){1'b1}}};
	localparam logic [LIM_W-1:0]  LIMIT_RST     = {LIM_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_DRIVE_MIN = 3'd3,
		REG_DRIVE_MAX = 3'd4,
		REG_LIMIT     = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic start;
		logic clear;
	} mac_cmd_t;

endpackage

// ===== sv/pidc_mac.sv =====
// ----------------------------------------------------------------------------
// PID controller digit-serial multiply-accumulate unit
// Adds a signed multiplicand times an unsigned multiplier to the accumulator,
// consuming one multiplier digit per cycle, least significant digit first.
// ----------------------------------------------------------------------------
module pidc_mac
	import pidc_pkg::*;
#(
	parameter int MC_W  = 48,
	parameter int MP_W  = 32,
	parameter int ACC_W = 82
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_cmd_t                cmd,
	input  logic signed [MC_W-1:0]  mcand,
	input  logic        [MP_W-1:0]  mplr,
	output logic                    busy,
	output logic signed [ACC_W-1:0] acc
);

	localparam int DIGITS = (MP_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MPP_W  = DIGITS * DIGIT_W;
	localparam int CNT_W  = $clog2(DIGITS + 1);

	logic [CNT_W-1:0]         cnt_q;
	logic [ACC_W-1:0]         mc_q;
	logic [ACC_W-1:0]         acc_q;
	logic [MPP_W-1:0]         mp_q;
	logic signed [ACC_W+DIGIT_W:0] pp;

	assign busy = (cnt_q != '0);
	assign acc  = $signed(acc_q);
	assign pp   = $signed(mc_q) * $signed({1'b0, mp_q[DIGIT_W-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= CNT_W'(DIGITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mc_q <= ACC_W'(mcand);
			mp_q <= MPP_W'(mplr);
			if (cmd.clear) begin
				acc_q <= '0;
			end
		end else if (busy) begin
			acc_q <= acc_q + pp[ACC_W-1:0];
			mc_q  <= mc_q << DIGIT_W;
			mp_q  <= mp_q >> DIGIT_W;
		end
	end

endmodule

// ===== sv/pidc_div.sv =====
// ----------------------------------------------------------------------------
// PID controller serial divider
// Restoring unsigned division that retires a fixed number of quotient bits
// per cycle; the dividend shifts out as the quotient shifts in.
// ----------------------------------------------------------------------------
module pidc_div
	import pidc_pkg::*;
#(
	parameter int N_W = 48,
	parameter int D_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic [N_W-1:0] quotient
);

	localparam int CYCLES = (N_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NP_W   = CYCLES * DIV_STEPS;
	localparam int CNT_W  = $clog2(CYCLES + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NP_W-1:0]  q_q;
	logic [NP_W-1:0]  q_d;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   rem_d;
	logic [D_W-1:0]   div_q;

	assign busy     = (cnt_q != '0);
	assign quotient = q_q[N_W-1:0];

	always_comb begin
		logic [D_W:0] trial;
		trial = '0;
		q_d   = q_q;
		rem_d = rem_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {rem_d, q_d[NP_W-1]};
			q_d   = {q_d[NP_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial  = trial - {1'b0, div_q};
				q_d[0] = 1'b1;
			end
			rem_d = trial[D_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(CYCLES);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= NP_W'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy) begin
			q_q   <= q_d;
			rem_q <= rem_d;
		end
	end

endmodule

// ===== sv/pid_controller_antiwindup_unit.sv =====
// ----------------------------------------------------------------------------
// PID controller with integral clamp
// Fixed-point PID step: saturated error, clamped integral, derivative over
// elapsed time and a gain-weighted sum clamped to the output limits.
// ----------------------------------------------------------------------------
// Usage:
// Software writes the gains, output limits and integral limit through the
// cfg_write/cfg_index/cfg_data port while the block is idle. Input
// transactions move on in_valid/in_stall, results on out_valid/out_stall.
// A step transaction (cmd low) produces one drive result; a clear
// transaction zeroes the integral and the previous error and produces none.
// A step result is registered as the block leaves its last state for idle,
// and the next transaction is not taken before the block is idle again; a
// clear leaves the block idle. The serial dividers retire two quotient bits
// per cycle, and the shared multiply-accumulate unit takes four multiplier
// bits per cycle for each of the three gains. The result waits in an output
// register while out_stall is high; a following step waits in its last
// state until that register frees up. Reset restores the register defaults
// and clears the integral, the previous error and any transaction in flight.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit
	import pidc_pkg::*;
#(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic        [CFG_IDX_W-1:0]  cfg_index,
	input  logic        [CFG_W-1:0]      cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic signed [DATA_WIDTH-1:0] target,
	input  logic signed [DATA_WIDTH-1:0] measurement,
	input  logic        [MS_W-1:0]       elapsed_ms,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] drive
);

	localparam int W       = DATA_WIDTH;
	localparam int PRODA_W = W + MS_W;
	localparam int PRODB_W = W + SCALE_W;
	localparam int INT_W   = (W + MS_W > LIM_W + 1) ? W + MS_W : LIM_W + 1;
	localparam int DER_W   = PRODB_W + 1;
	localparam int ACC_W   = GAIN_W + INT_W + 2;
	localparam int SH_W    = ACC_W - FRAC_BITS;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'h0001,
		ST_ERR   = 14'h0002,
		ST_DIFF  = 14'h0004,
		ST_ABS   = 14'h0008,
		ST_SCALE = 14'h0010,
		ST_PROD  = 14'h0020,
		ST_DIV   = 14'h0040,
		ST_SIGN  = 14'h0080,
		ST_INTEG = 14'h0100,
		ST_CLAMP = 14'h0200,
		ST_MACD  = 14'h0400,
		ST_MACI  = 14'h0800,
		ST_HI    = 14'h1000,
		ST_LO    = 14'h2000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic        [GAIN_W-1:0] gain_p_q;
	logic        [GAIN_W-1:0] gain_i_q;
	logic        [GAIN_W-1:0] gain_d_q;
	logic signed [DRV_W-1:0]  dmin_q;
	logic signed [DRV_W-1:0]  dmax_q;
	logic        [LIM_W-1:0]  limit_q;

	logic signed [W-1:0]     tgt_q;
	logic signed [W-1:0]     meas_q;
	logic        [MS_W-1:0]  ms_q;
	logic signed [W-1:0]     err_q;
	logic signed [W-1:0]     last_q;
	logic signed [W:0]       diff_q;
	logic        [W-1:0]     eabs_q;
	logic        [W:0]       dabs_q;
	logic signed [INT_W-1:0] incr_q;
	logic signed [DER_W-1:0] deriv_q;
	logic signed [INT_W:0]   isum_q;
	logic signed [INT_W-1:0] integ_q;
	logic signed [SH_W-1:0]  sh_q;
	logic signed [W-1:0]     drive_q;
	logic                    out_valid_q;

	logic signed [W:0]       raw_err;
	logic signed [W-1:0]     err_sat;
	logic signed [INT_W:0]   lim_s;
	logic signed [SH_W-1:0]  sh;
	logic signed [SH_W-1:0]  dmax_ext;
	logic signed [SH_W-1:0]  dmin_ext;
	logic signed [SH_W-1:0]  lo_val;
	logic                    accept;
	logic                    out_free;

	mac_cmd_t                 maca_cmd;
	mac_cmd_t                 macb_cmd;
	mac_cmd_t                 mac_cmd;
	logic                     maca_busy;
	logic                     macb_busy;
	logic                     mac_busy;
	logic signed [PRODA_W-1:0] maca_acc;
	logic signed [PRODB_W-1:0] macb_acc;
	logic signed [ACC_W-1:0]  mac_acc;
	logic signed [INT_W-1:0]  mac_mcand;
	logic        [GAIN_W-1:0] mac_mplr;
	logic                     div_start;
	logic                     diva_busy;
	logic                     divb_busy;
	logic        [PRODA_W-1:0] diva_q;
	logic        [PRODB_W-1:0] divb_q;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	assign raw_err  = (W + 1)'(tgt_q) - (W + 1)'(meas_q);
	assign lim_s    = $signed((INT_W + 1)'(limit_q));
	assign sh       = $signed(mac_acc[ACC_W-1:FRAC_BITS]);
	assign dmax_ext = SH_W'(dmax_q);
	assign dmin_ext = SH_W'(dmin_q);
	assign lo_val   = (sh_q < dmin_ext) ? dmin_ext : sh_q;

	always_comb begin
		if (raw_err[W] != raw_err[W-1]) begin
			err_sat = raw_err[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			err_sat = raw_err[W-1:0];
		end
	end

	assign maca_cmd.start = (state_q == ST_ABS);
	assign maca_cmd.clear = 1'b1;
	assign macb_cmd.start = (state_q == ST_SCALE);
	assign macb_cmd.clear = 1'b1;
	assign div_start      = (state_q == ST_PROD) && !maca_busy && !macb_busy;

	assign mac_cmd.start = (state_q == ST_DIFF) || (state_q == ST_CLAMP) ||
		((state_q == ST_MACD) && !mac_busy);
	assign mac_cmd.clear = (state_q == ST_DIFF);

	always_comb begin
		priority if (state_q == ST_DIFF) begin
			mac_mcand = INT_W'(err_q);
			mac_mplr  = gain_p_q;
		end else if (state_q == ST_CLAMP) begin
			mac_mcand = INT_W'(deriv_q);
			mac_mplr  = gain_d_q;
		end else begin
			mac_mcand = integ_q;
			mac_mplr  = gain_i_q;
		end
	end

	pidc_mac #(
		.MC_W  (W + 1),
		.MP_W  (MS_W),
		.ACC_W (PRODA_W)
	) u_mac_time (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (maca_cmd),
		.mcand  ($signed({1'b0, eabs_q})),
		.mplr   (ms_q),
		.busy   (maca_busy),
		.acc    (maca_acc)
	);

	pidc_mac #(
		.MC_W  (W + 2),
		.MP_W  (SCALE_W),
		.ACC_W (PRODB_W)
	) u_mac_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (macb_cmd),
		.mcand  ($signed({1'b0, dabs_q})),
		.mplr   (SCALE_W'(SCALE)),
		.busy   (macb_busy),
		.acc    (macb_acc)
	);

	pidc_div #(
		.N_W (PRODA_W),
		.D_W (SCALE_W)
	) u_div_incr (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (maca_acc),
		.divisor  (SCALE_W'(SCALE)),
		.busy     (diva_busy),
		.quotient (diva_q)
	);

	pidc_div #(
		.N_W (PRODB_W),
		.D_W (MS_W)
	) u_div_deriv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (macb_acc),
		.divisor  (ms_q),
		.busy     (divb_busy),
		.quotient (divb_q)
	);

	pidc_mac #(
		.MC_W  (INT_W),
		.MP_W  (GAIN_W),
		.ACC_W (ACC_W)
	) u_mac_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.mcand  (mac_mcand),
		.mplr   (mac_mplr),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_STEP)) begin
					state_d = ST_ERR;
				end
			end
			ST_ERR:   state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_ABS;
			ST_ABS:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_PROD;
			ST_PROD: begin
				if (div_start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!diva_busy && !divb_busy && !mac_busy) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN:  state_d = ST_INTEG;
			ST_INTEG: state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_MACD;
			ST_MACD: begin
				if (!mac_busy) begin
					state_d = ST_MACI;
				end
			end
			ST_MACI: begin
				if (!mac_busy) begin
					state_d = ST_HI;
				end
			end
			ST_HI: state_d = ST_LO;
			ST_LO: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
			dmin_q   <= DRIVE_MIN_RST;
			dmax_q   <= DRIVE_MAX_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GAIN_P:    gain_p_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:    gain_i_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:    gain_d_q <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_MIN: dmin_q   <= cfg_data[DRV_W-1:0];
				REG_DRIVE_MAX: dmax_q   <= cfg_data[DRV_W-1:0];
				REG_LIMIT:     limit_q  <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (accept && (cmd == CMD_CLEAR)) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (state_q == ST_CLAMP) begin
			if (isum_q > lim_s) begin
				integ_q <= INT_W'(lim_s);
			end else if (isum_q < -lim_s) begin
				integ_q <= INT_W'(-lim_s);
			end else begin
				integ_q <= INT_W'(isum_q);
			end
		end else if ((state_q == ST_LO) && out_free) begin
			last_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q  <= target;
			meas_q <= measurement;
			ms_q   <= (elapsed_ms == '0) ? MS_W'(1) : elapsed_ms;
		end
		if (state_q == ST_ERR) begin
			err_q <= err_sat;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= (W + 1)'(err_q) - (W + 1)'(last_q);
			eabs_q <= err_q[W-1] ? (~err_q + 1'b1) : err_q;
		end
		if (state_q == ST_ABS) begin
			dabs_q <= diff_q[W] ? (~diff_q + 1'b1) : diff_q;
		end
		if (state_q == ST_SIGN) begin
			incr_q  <= err_q[W-1] ? -$signed(INT_W'(diva_q)) : $signed(INT_W'(diva_q));
			deriv_q <= diff_q[W] ? -$signed(DER_W'(divb_q)) : $signed(DER_W'(divb_q));
		end
		if (state_q == ST_INTEG) begin
			isum_q <= (INT_W + 1)'(integ_q) + (INT_W + 1)'(incr_q);
		end
		if (state_q == ST_HI) begin
			sh_q <= (sh > dmax_ext) ? dmax_ext : sh;
		end
		if ((state_q == ST_LO) && out_free) begin
			drive_q <= W'(lo_val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_LO) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_clear_zeroes_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_CLEAR)) |=> ((integ_q == '0) && (last_q == '0)))
		else $error("clear transaction did not zero the integral and previous error");

	a_result_from_last_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_LO))
		else $error("result presented outside the final state");

	a_mac_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mac_cmd.start |-> !mac_busy)
		else $error("multiply-accumulate unit restarted while busy");

	a_units_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> (!diva_busy && !divb_busy && !mac_busy))
		else $error("quotients used before the serial units finished");

endmodule

// ===== tb/tb_pid_controller_antiwindup_unit.sv =====
// ----------------------------------------------------------------------------
// PID controller with integral clamp testbench
// Drives step and clear transactions with random gaps and random result
// stalls. Each accepted step is predicted with exact wide arithmetic and
// checked against the drive result. Register settings are changed between
// phases, including the extremes of every register.
// ----------------------------------------------------------------------------
module tb_pid_controller_antiwindup_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pidc_pkg::*;

	localparam int SETTLE = 64;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	logic        [CFG_IDX_W-1:0] cfg_index = '0;
	logic        [CFG_W-1:0]     cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        cmd = CMD_STEP;
	logic signed [DRV_W-1:0]     target = '0;
	logic signed [DRV_W-1:0]     measurement = '0;
	logic        [MS_W-1:0]      elapsed_ms = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [DRV_W-1:0]     drive;

	logic        [GAIN_W-1:0] k_p = GAIN_P_RST;
	logic        [GAIN_W-1:0] k_i = GAIN_I_RST;
	logic        [GAIN_W-1:0] k_d = GAIN_D_RST;
	logic signed [DRV_W-1:0]  lo_drive = DRIVE_MIN_RST;
	logic signed [DRV_W-1:0]  hi_drive = DRIVE_MAX_RST;
	logic        [LIM_W-1:0]  windup_limit = LIMIT_RST;
	longint                   integ_sum = 0;
	longint                   prev_err = 0;

	logic signed [DRV_W-1:0] expected_drive[$];
	logic signed [DRV_W-1:0] want;
	int                      errors = 0;
	int                      idle_max = 17;

	pid_controller_antiwindup_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.target(target),
		.measurement(measurement),
		.elapsed_ms(elapsed_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive(drive)
	);

	always #1 clk = ~clk;

	function automatic logic signed [95:0] weigh(logic [GAIN_W-1:0] g, longint x);
		logic signed [95:0] gs;
		logic signed [95:0] xs;
		gs = {64'd0, g};
		xs = x;
		return gs * xs;
	endfunction

	function automatic logic signed [DRV_W-1:0] predict_drive(logic signed [DRV_W-1:0] tgt,
			logic signed [DRV_W-1:0] meas, logic [MS_W-1:0] ms_in);
		longint err;
		longint ms;
		longint lim;
		longint deriv;
		logic signed [95:0] acc;
		logic signed [95:0] hi;
		logic signed [95:0] lo;
		err = longint'(tgt) - longint'(meas);
		if (err > 64'sd2147483647) err = 64'sd2147483647;
		if (err < -64'sd2147483648) err = -64'sd2147483648;
		ms = (ms_in == '0) ? 1 : longint'(ms_in);
		integ_sum = integ_sum + (err * ms) / SCALE;
		lim = longint'({17'd0, windup_limit});
		if (integ_sum > lim) integ_sum = lim;
		if (integ_sum < -lim) integ_sum = -lim;
		deriv = ((err - prev_err) * SCALE) / ms;
		acc = weigh(k_p, err) + weigh(k_i, integ_sum) + weigh(k_d, deriv);
		acc = acc >>> DEF_FRAC_BITS;
		hi = hi_drive;
		lo = lo_drive;
		if (acc > hi) acc = hi;
		if (acc < lo) acc = lo;
		prev_err = err;
		return acc[DRV_W-1:0];
	endfunction

	task automatic send_item(logic c, logic [DRV_W-1:0] t, logic [DRV_W-1:0] m,
			logic [MS_W-1:0] ms);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		target <= t;
		measurement <= m;
		elapsed_ms <= ms;
		do @(posedge clk); while (in_stall);
		if (c == CMD_CLEAR) begin
			integ_sum = 0;
			prev_err = 0;
		end else begin
			expected_drive.push_back(predict_drive(t, m, ms));
		end
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic step(logic [DRV_W-1:0] t, logic [DRV_W-1:0] m, logic [MS_W-1:0] ms);
		send_item(CMD_STEP, t, m, ms);
	endtask

	task automatic hold_until_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_drive.size() != 0) @(posedge clk);
	endtask

	task automatic drain();
		hold_until_done();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_GAIN_P:    k_p = value[GAIN_W-1:0];
			REG_GAIN_I:    k_i = value[GAIN_W-1:0];
			REG_GAIN_D:    k_d = value[GAIN_W-1:0];
			REG_DRIVE_MIN: lo_drive = value[DRV_W-1:0];
			REG_DRIVE_MAX: hi_drive = value[DRV_W-1:0];
			REG_LIMIT:     windup_limit = value[LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
			logic [GAIN_W-1:0] d, logic [DRV_W-1:0] mn, logic [DRV_W-1:0] mx,
			logic [LIM_W-1:0] lim);
		drain();
		write_reg(REG_GAIN_P, CFG_W'(p));
		write_reg(REG_GAIN_I, CFG_W'(i));
		write_reg(REG_GAIN_D, CFG_W'(d));
		write_reg(REG_DRIVE_MIN, CFG_W'(mn));
		write_reg(REG_DRIVE_MAX, CFG_W'(mx));
		write_reg(REG_LIMIT, CFG_W'(lim));
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain(int unsigned span);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom();
			default: return $urandom_range(0, span);
		endcase
	endfunction

	function automatic logic [DRV_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0, 1: return $urandom();
			2: return $urandom_range(0, 1) ? DRIVE_MAX_RST : DRIVE_MIN_RST;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic logic [MS_W-1:0] pick_elapsed();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return r[MS_W-1:0];
			default: return MS_W'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic random_settings();
		logic [DRV_W-1:0] mn;
		logic [DRV_W-1:0] mx;
		logic [63:0]      wide;
		logic [LIM_W-1:0] lim;
		case ($urandom_range(0, 3))
			0: begin
				mn = $urandom();
				mx = $urandom();
			end
			1: begin
				mn = DRIVE_MIN_RST;
				mx = DRIVE_MAX_RST;
			end
			default: begin
				mn = 32'd0 - $urandom_range(32'h0001_0000, 32'h1000_0000);
				mx = $urandom_range(32'h0001_0000, 32'h1000_0000);
			end
		endcase
		wide = {$urandom(), $urandom()};
		case ($urandom_range(0, 4))
			0: lim = LIMIT_RST;
			1: lim = wide[LIM_W-1:0];
			2: lim = '0;
			default: lim = LIM_W'($urandom_range(0, 32'h1000_0000));
		endcase
		apply_settings(pick_gain(32'h0004_0000), pick_gain(32'h0008_0000), pick_gain(1024),
			mn, mx, lim);
	endtask

	task automatic test_reset_defaults();
		step(DRIVE_MAX_RST, DRIVE_MIN_RST, 16'd5);
		step(DRIVE_MIN_RST, DRIVE_MAX_RST, 16'd0);
		step(32'd0, 32'd0, 16'hFFFF);
		step(32'h1234_0000, 32'h0001_0000, 16'd1);
	endtask

	task automatic test_extreme_gains();
		apply_settings('1, '1, '1, DRIVE_MIN_RST, DRIVE_MAX_RST, LIMIT_RST);
		step(DRIVE_MAX_RST, DRIVE_MIN_RST, 16'hFFFF);
		step(DRIVE_MIN_RST, DRIVE_MAX_RST, 16'd1);
		step(DRIVE_MIN_RST, DRIVE_MAX_RST, 16'd0);
	endtask

	task automatic test_integral_clamp();
		apply_settings('0, 32'h0001_0000, '0, DRIVE_MIN_RST, DRIVE_MAX_RST, 47'h0_000A_0000);
		repeat (4) step(32'h0005_0000, 32'd0, 16'd1000);
		step(32'd0, 32'h0032_0000, 16'd1000);
		apply_settings(32'h0001_0000, 32'h0001_0000, '0, DRIVE_MIN_RST, DRIVE_MAX_RST, '0);
		step(32'h0003_0000, 32'd0, 16'd500);
	endtask

	task automatic test_inverted_limits();
		apply_settings(32'h0001_0000, '0, '0, 32'h0064_0000, 32'hFF9C_0000, LIMIT_RST);
		step(32'h0200_0000, 32'd0, 16'd10);
		step(32'hFE00_0000, 32'd0, 16'd10);
		apply_settings(32'h0001_0000, '0, '0, 32'h0001_0000, 32'h0001_0000, LIMIT_RST);
		step(32'd0, 32'h0005_0000, 16'd3);
	endtask

	task automatic test_clear();
		apply_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_0040,
			DRIVE_MIN_RST, DRIVE_MAX_RST, LIMIT_RST);
		step(32'h0010_0000, 32'd0, 16'd20);
		send_item(CMD_CLEAR, $urandom(), $urandom(), MS_W'($urandom()));
		step(32'h0010_0000, 32'd0, 16'd20);
		send_item(CMD_CLEAR, '0, '0, '0);
		send_item(CMD_CLEAR, '1, '1, '1);
		step(32'hFFF0_0000, 32'd0, 16'd7);
	endtask

	task automatic test_random_settings();
		repeat (8) begin
			random_settings();
			repeat (140) begin
				if ($urandom_range(0, 15) == 0) begin
					send_item(CMD_CLEAR, $urandom(), $urandom(), MS_W'($urandom()));
				end else begin
					step(pick_operand(), pick_operand(), pick_elapsed());
				end
				if ($urandom_range(0, 99) == 0) hold_until_done();
			end
		end
	endtask

	task automatic test_back_to_back();
		apply_settings(32'h0002_0000, 32'h0000_4000, 32'h0000_0020,
			32'hF000_0000, 32'h1000_0000, 47'h0_1000_0000);
		idle_max = 0;
		repeat (40) step(pick_operand(), pick_operand(), pick_elapsed());
		hold_until_done();
		idle_max = 17;
	endtask

	// The receiver holds some results for a random number of cycles once they show up.
	initial begin
		int n;
		forever begin
			n = $urandom_range(0, idle_max);
			@(negedge clk);
			out_stall <= (n != 0);
			if (n != 0) begin
				do @(posedge clk); while (!out_valid);
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_drive.size() == 0) begin
				$display("%0t: drive expected none actual %0d", $time, drive);
				errors++;
			end else begin
				want = expected_drive.pop_front();
				if (drive !== want) begin
					$display("%0t: drive expected %0d actual %0d", $time, want, drive);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("pid_controller_antiwindup_unit: mismatch");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_extreme_gains();
		test_integral_clamp();
		test_inverted_limits();
		test_clear();
		test_random_settings();
		test_back_to_back();
		drain();
		if (errors == 0) begin
			$display("pid_controller_antiwindup_unit: match");
		end else begin
			$display("pid_controller_antiwindup_unit: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/pidc_pkg.sv
sv/pidc_mac.sv
sv/pidc_div.sv
sv/pid_controller_antiwindup_unit.sv
tb/tb_pid_controller_antiwindup_unit.sv
